@@ src/icdf_pkg.sv @@
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants of the 2-d inverse cdf sampler.
// ----------------------------------------------------------------------------
package icdf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int CDF_BITS    = FRAC_BITS + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int FLUX_STEPS  = 18 + 2 * FRAC_BITS;

	localparam logic [2:0] OP_SAMPLE  = 3'd0;
	localparam logic [2:0] OP_WR_ROW  = 3'd1;
	localparam logic [2:0] OP_WR_COL  = 3'd2;
	localparam logic [2:0] OP_WR_PROB = 3'd3;
	localparam logic [2:0] OP_WR_IMG  = 3'd4;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;
	localparam logic [1:0] REG_SAMPLES  = 2'd3;

	localparam logic signed [17:0] COORD_ONE     = 18'(ONE);
	localparam logic signed [17:0] COORD_NEG_ONE = -18'(ONE);
	localparam logic [31:0]        FLUX_MAX      = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_SAMPLE,
		CMD_REJECT,
		CMD_WR_ROW,
		CMD_WR_COL,
		CMD_WR_PROB,
		CMD_WR_IMG
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [13:0]         index;
		logic [1:0]          channel;
		logic [31:0]         value;
		logic [CDF_BITS-1:0] row_u;
		logic [CDF_BITS-1:0] col_u;
		logic [15:0]         row_jit;
		logic [15:0]         col_jit;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_CMP,
		ST_BASE,
		ST_COL_RD,
		ST_COL_CMP,
		ST_PIX,
		ST_PROB_RD,
		ST_PROB,
		ST_DIV_Y,
		ST_DIV_X,
		ST_IMG_RD,
		ST_IMG,
		ST_FLUX,
		ST_EMIT
	} state_t;

endpackage

@@ src/icdf_if.sv @@
// ----------------------------------------------------------------------------
// icdf item and result channels
// Valid/ready channels carrying sampler items and flux results.
// ----------------------------------------------------------------------------
interface icdf_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [13:0]        write_index;
	logic [1:0]         write_channel;
	logic [31:0]        write_value;
	logic signed [19:0] row_uniform;
	logic signed [19:0] col_uniform;
	logic [15:0]        row_jitter;
	logic [15:0]        col_jitter;

	modport source (output valid, operation, write_index, write_channel, write_value,
		row_uniform, col_uniform, row_jitter, col_jitter, input ready);
	modport sink (input valid, operation, write_index, write_channel, write_value,
		row_uniform, col_uniform, row_jitter, col_jitter, output ready);
endinterface

interface icdf_result_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] x_coord;
	logic signed [17:0] y_coord;
	logic [1:0]         flux_channel;
	logic [31:0]        flux_value;
	logic               rejected;
	logic               last;

	modport source (output valid, x_coord, y_coord, flux_channel, flux_value, rejected,
		last, input ready);
	modport sink (input valid, x_coord, y_coord, flux_channel, flux_value, rejected,
		last, output ready);
endinterface

@@ src/inverse_cdf_2d_sampler.sv @@
// ----------------------------------------------------------------------------
// inverse_cdf_2d_sampler
// 2-d inverse cdf sampler over a piecewise-constant image distribution.
//
// item channel: table writes (row cdf, column cdf, probability, image) and
// sample items carrying two Q3.16 uniforms and two Q0.16 jitters. result
// channel: one result per image channel of a sample, last on the final one.
// cfg port: width, height, channel count and sample total, written while idle.
//
// A write is applied by the back end as it leaves the queue. A sample runs
// the row and column searches (one table read and compare per step) and
// the bit-serial coordinate divider before its first flux, then one flux
// per channel in the one-bit-per-cycle flux divider; a zero probability
// skips the divider. A rejected sample skips the searches and both dividers.
// Items queue in a four-entry command queue so the input keeps
// flowing while the back end works or the output stalls.
// A stalled receiver holds the result register; the back end waits.
// Reset clears control state and loads register defaults 128, 128, 1, 1;
// tables stay undefined until written.
// ----------------------------------------------------------------------------
module inverse_cdf_2d_sampler import icdf_pkg::*; #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int MAX_CHANNELS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_wdata,
	icdf_item_if.sink     item,
	icdf_result_if.source result
);

	localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
	localparam int NC_BITS = $clog2(MAX_CHANNELS + 1);

	logic [7:0]         cfg_width_q;
	logic [7:0]         cfg_height_q;
	logic [2:0]         cfg_chan_q;
	logic [23:0]        cfg_samples_q;

	logic [W_BITS-1:0]  width;
	logic [H_BITS-1:0]  height;
	logic [NC_BITS-1:0] channels;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	cmd_t               q_din;
	cmd_t               q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q   <= 8'd128;
			cfg_height_q  <= 8'd128;
			cfg_chan_q    <= 3'd1;
			cfg_samples_q <= 24'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH:    cfg_width_q   <= cfg_wdata[7:0];
				REG_HEIGHT:   cfg_height_q  <= cfg_wdata[7:0];
				REG_CHANNELS: cfg_chan_q    <= cfg_wdata[2:0];
				REG_SAMPLES:  cfg_samples_q <= cfg_wdata;
				default:      cfg_samples_q <= cfg_samples_q;
			endcase
		end
	end

	// saturate registers into their usable ranges
	always_comb begin
		if (cfg_width_q == '0) begin
			width = W_BITS'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			width = W_BITS'(MAX_WIDTH);
		end else begin
			width = W_BITS'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			height = H_BITS'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			height = H_BITS'(MAX_HEIGHT);
		end else begin
			height = H_BITS'(cfg_height_q);
		end
		if (cfg_chan_q == '0) begin
			channels = NC_BITS'(1);
		end else if (32'(cfg_chan_q) > 32'(MAX_CHANNELS)) begin
			channels = NC_BITS'(MAX_CHANNELS);
		end else begin
			channels = NC_BITS'(cfg_chan_q);
		end
	end

	icdf_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_din)
	);

	icdf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_head)
	);

	icdf_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.width    (width),
		.height   (height),
		.channels (channels),
		.samples  (cfg_samples_q),
		.result   (result)
	);

	a_reject_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.rejected |-> result.flux_value == '0
			&& result.x_coord == COORD_NEG_ONE && result.y_coord == COORD_NEG_ONE)
		else $error("rejected sample result not neutral");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.x_coord >= COORD_NEG_ONE && result.x_coord <= COORD_ONE
			&& result.y_coord >= COORD_NEG_ONE && result.y_coord <= COORD_ONE)
		else $error("coordinate outside unit range");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last |-> result.flux_channel == 2'(channels - NC_BITS'(1)))
		else $error("last flag on wrong channel");

endmodule

@@ src/icdf_front.sv @@
// ----------------------------------------------------------------------------
// icdf_front
// Accepts items, drops ignored ones and classifies the rest into commands.
// ----------------------------------------------------------------------------
module icdf_front import icdf_pkg::*; #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int MAX_CHANNELS = 4
) (
	icdf_item_if.sink item,
	input  logic      q_full,
	output logic      q_push,
	output cmd_t      q_data
);

	localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;

	logic keep;
	logic bad_row_u;
	logic bad_col_u;

	always_comb begin
		bad_row_u = item.row_uniform[19] || (item.row_uniform[18:0] > 19'(ONE));
		bad_col_u = item.col_uniform[19] || (item.col_uniform[18:0] > 19'(ONE));
		keep = 1'b0;
		q_data.kind = CMD_SAMPLE;
		case (item.operation)
			OP_SAMPLE: begin
				keep = 1'b1;
				q_data.kind = (bad_row_u || bad_col_u) ? CMD_REJECT : CMD_SAMPLE;
			end
			OP_WR_ROW: begin
				keep = 32'(item.write_index) < 32'(MAX_HEIGHT);
				q_data.kind = CMD_WR_ROW;
			end
			OP_WR_COL: begin
				keep = 32'(item.write_index) < 32'(PIXELS);
				q_data.kind = CMD_WR_COL;
			end
			OP_WR_PROB: begin
				keep = 32'(item.write_index) < 32'(PIXELS);
				q_data.kind = CMD_WR_PROB;
			end
			OP_WR_IMG: begin
				keep = (32'(item.write_index) < 32'(PIXELS))
					&& (32'(item.write_channel) < 32'(MAX_CHANNELS));
				q_data.kind = CMD_WR_IMG;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		q_data.index   = item.write_index;
		q_data.channel = item.write_channel;
		q_data.value   = item.write_value;
		q_data.row_u   = item.row_uniform[CDF_BITS-1:0];
		q_data.col_u   = item.col_uniform[CDF_BITS-1:0];
		q_data.row_jit = item.row_jitter;
		q_data.col_jit = item.col_jitter;
	end

	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full && keep;

endmodule

@@ src/icdf_queue.sv @@
// ----------------------------------------------------------------------------
// icdf_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module icdf_queue import icdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t dout
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == (PTR_BITS+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_BITS+1)'(1);
			end
		end
	end

endmodule

@@ src/icdf_flux.sv @@
// ----------------------------------------------------------------------------
// icdf_flux
// Bit-serial chained divider: floor(floor(value*4*2^32 / prob) / den),
// saturated to 32 bits; stage two takes each stage-one bit in the next cycle.
// ----------------------------------------------------------------------------
module icdf_flux import icdf_pkg::*; #(
	parameter int D_BITS = 38
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       value,
	input  logic [31:0]       prob,
	input  logic [D_BITS-1:0] den,
	output logic              done,
	output logic [31:0]       result
);

	localparam int CNT_BITS = $clog2(FLUX_STEPS + 2);

	logic [17:0]         a_q;
	logic [31:0]         r1_q;
	logic [D_BITS-1:0]   r2_q;
	logic [31:0]         quo_q;
	logic                sat_q;
	logic                b1_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [32:0]         r1s;
	logic                ge1;
	logic [32:0]         r1n;
	logic [D_BITS:0]     r2s;
	logic                ge2;
	logic [D_BITS:0]     r2n;
	logic [32:0]         qn;

	always_comb begin
		r1s = {r1_q, a_q[17]};
		ge1 = r1s >= {1'b0, prob};
		r1n = ge1 ? r1s - {1'b0, prob} : r1s;
		r2s = {r2_q, b1_q};
		ge2 = r2s >= {1'b0, den};
		r2n = ge2 ? r2s - {1'b0, den} : r2s;
		qn  = {quo_q, ge2};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {value, 2'b00};
			r1_q  <= '0;
			r2_q  <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			b1_q  <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q < CNT_BITS'(FLUX_STEPS)) begin
				a_q  <= {a_q[16:0], 1'b0};
				r1_q <= r1n[31:0];
				b1_q <= ge1;
			end
			if (cnt_q != '0) begin
				r2_q  <= r2n[D_BITS-1:0];
				quo_q <= qn[31:0];
				sat_q <= sat_q | qn[32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(FLUX_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = sat_q ? FLUX_MAX : quo_q;

endmodule

@@ src/icdf_back.sv @@
// ----------------------------------------------------------------------------
// icdf_back
// Table memories, row and column searches, coordinate division and the
// per-channel flux sequence with its output register.
// ----------------------------------------------------------------------------
module icdf_back import icdf_pkg::*; #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	input  cmd_t                                  q_head,
	output logic                                  q_pop,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]        width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]       height,
	input  logic [$clog2(MAX_CHANNELS+1)-1:0]     channels,
	input  logic [23:0]                           samples,
	icdf_result_if.source                         result
);

	localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
	localparam int DIM_MAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
	localparam int DD_BITS   = $clog2(DIM_MAX + 1);
	localparam int IDX_BITS  = $clog2(DIM_MAX);
	localparam int ROW_AW    = $clog2(MAX_HEIGHT);
	localparam int PIX_AW    = $clog2(PIXELS);
	localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NC_BITS   = $clog2(MAX_CHANNELS + 1);
	localparam int IMG_DEPTH = MAX_CHANNELS * PIXELS;
	localparam int IMG_AW    = $clog2(IMG_DEPTH);
	localparam int POS_BITS  = $clog2(3 * DIM_MAX) + FRAC_BITS + 1;
	localparam int CNT_BITS  = $clog2(POS_BITS + 1);
	localparam int WH_BITS   = W_BITS + H_BITS;
	localparam int D_BITS    = WH_BITS + 24;
	localparam int QV_BITS   = FRAC_BITS + 2;

	// table memories
	logic [CDF_BITS-1:0] row_mem [MAX_HEIGHT];
	logic [CDF_BITS-1:0] col_mem [PIXELS];
	logic [31:0]         prob_mem [PIXELS];
	logic [15:0]         img_mem [IMG_DEPTH];

	logic [CDF_BITS-1:0] row_rd_q;
	logic [CDF_BITS-1:0] col_rd_q;
	logic [31:0]         prob_rd_q;
	logic [15:0]         img_rd_q;

	state_t              state_q;
	state_t              state_d;

	logic [CDF_BITS-1:0] ru_q;
	logic [CDF_BITS-1:0] cu_q;
	logic [15:0]         rj_q;
	logic [15:0]         cj_q;
	logic                rej_q;
	logic [IDX_BITS-1:0] lo_q;
	logic [IDX_BITS-1:0] hi_q;
	logic [IDX_BITS-1:0] row_q;
	logic [IDX_BITS-1:0] col_q;
	logic [PIX_AW-1:0]   base_q;
	logic [PIX_AW-1:0]   pix_q;
	logic [WH_BITS-1:0]  wh_q;
	logic [D_BITS-1:0]   den_q;
	logic [31:0]         p_q;
	logic [POS_BITS-1:0] dnum_q;
	logic [DD_BITS-1:0]  drem_q;
	logic [DD_BITS-1:0]  ddiv_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic signed [17:0]  x_q;
	logic signed [17:0]  y_q;
	logic [CH_BITS-1:0]  ch_q;
	logic [31:0]         flux_q;

	logic                out_valid_q;
	logic signed [17:0]  out_x_q;
	logic signed [17:0]  out_y_q;
	logic [1:0]          out_ch_q;
	logic [31:0]         out_flux_q;
	logic                out_rej_q;
	logic                out_last_q;

	logic                wr_row;
	logic                wr_col;
	logic                wr_prob;
	logic                wr_img;
	logic                flux_start;
	logic                emit_load;
	logic                out_free;
	logic                is_last;
	logic                search_more;
	logic [IDX_BITS-1:0] mid;
	logic [IDX_BITS:0]   mid_sum;
	logic [PIX_AW-1:0]   col_addr;
	logic [IMG_AW-1:0]   img_wr_addr;
	logic [IMG_AW-1:0]   img_rd_addr;
	logic [DD_BITS:0]    drs;
	logic                dge;
	logic [DD_BITS:0]    drn;
	logic [POS_BITS-1:0] quot_next;
	logic                div_last;
	logic signed [19:0]  qv;
	logic signed [19:0]  yv;
	logic signed [19:0]  xv;
	logic signed [17:0]  y_coord_n;
	logic signed [17:0]  x_coord_n;
	logic [POS_BITS-1:0] num_y;
	logic [POS_BITS-1:0] num_x;
	logic [23:0]         st;
	logic                flux_done;
	logic [31:0]         flux_res;

	assign st          = (samples == '0) ? 24'd1 : samples;
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[IDX_BITS:1];
	assign search_more = hi_q > lo_q;
	assign col_addr    = base_q + PIX_AW'(mid);
	assign img_wr_addr = IMG_AW'(int'(q_head.channel) * PIXELS + int'(q_head.index));
	assign img_rd_addr = IMG_AW'(int'(ch_q) * PIXELS + int'(pix_q));
	assign out_free    = !out_valid_q || result.ready;
	assign is_last     = NC_BITS'(ch_q) + NC_BITS'(1) == channels;
	assign div_last    = cnt_q == CNT_BITS'(POS_BITS - 1);

	// restoring division step and coordinate mapping
	always_comb begin
		drs       = {drem_q, dnum_q[POS_BITS-1]};
		dge       = drs >= {1'b0, ddiv_q};
		drn       = dge ? drs - {1'b0, ddiv_q} : drs;
		quot_next = {dnum_q[POS_BITS-2:0], dge};
		qv        = $signed(20'(quot_next[QV_BITS-1:0]));
		yv        = qv - 20'(2 * ONE);
		xv        = 20'(2 * ONE) - qv;
		y_coord_n = (yv < 20'(COORD_NEG_ONE)) ? COORD_NEG_ONE : 18'(yv);
		x_coord_n = (xv > 20'(COORD_ONE)) ? COORD_ONE : 18'(xv);
		num_y     = (POS_BITS'(row_q) << (FRAC_BITS + 1)) + (POS_BITS'(rj_q) << 1)
			+ (POS_BITS'(height) << FRAC_BITS) - POS_BITS'(ONE);
		num_x     = (POS_BITS'(col_q) << (FRAC_BITS + 1)) + (POS_BITS'(cj_q) << 1)
			+ (POS_BITS'(width) << FRAC_BITS) - POS_BITS'(ONE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_head.kind == CMD_SAMPLE) begin
						state_d = ST_ROW_RD;
					end else if (q_head.kind == CMD_REJECT) begin
						state_d = ST_IMG_RD;
					end
				end
			end
			ST_ROW_RD:  state_d = search_more ? ST_ROW_CMP : ST_BASE;
			ST_ROW_CMP: state_d = ST_ROW_RD;
			ST_BASE:    state_d = ST_COL_RD;
			ST_COL_RD:  state_d = search_more ? ST_COL_CMP : ST_PIX;
			ST_COL_CMP: state_d = ST_COL_RD;
			ST_PIX:     state_d = ST_PROB_RD;
			ST_PROB_RD: state_d = ST_PROB;
			ST_PROB:    state_d = ST_DIV_Y;
			ST_DIV_Y:   state_d = div_last ? ST_DIV_X : ST_DIV_Y;
			ST_DIV_X:   state_d = div_last ? ST_IMG_RD : ST_DIV_X;
			ST_IMG_RD:  state_d = ST_IMG;
			ST_IMG:     state_d = (!rej_q && p_q != '0) ? ST_FLUX : ST_EMIT;
			ST_FLUX:    state_d = flux_done ? ST_EMIT : ST_FLUX;
			ST_EMIT: begin
				if (out_free) begin
					state_d = is_last ? ST_IDLE : ST_IMG_RD;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop      = 1'b0;
		wr_row     = 1'b0;
		wr_col     = 1'b0;
		wr_prob    = 1'b0;
		wr_img     = 1'b0;
		flux_start = 1'b0;
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop   = !q_empty;
				wr_row  = !q_empty && q_head.kind == CMD_WR_ROW;
				wr_col  = !q_empty && q_head.kind == CMD_WR_COL;
				wr_prob = !q_empty && q_head.kind == CMD_WR_PROB;
				wr_img  = !q_empty && q_head.kind == CMD_WR_IMG;
			end
			ST_IMG:  flux_start = !rej_q && p_q != '0;
			ST_EMIT: emit_load = out_free;
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_row) begin
			row_mem[ROW_AW'(q_head.index)] <= q_head.value[CDF_BITS-1:0];
		end
		if (wr_col) begin
			col_mem[PIX_AW'(q_head.index)] <= q_head.value[CDF_BITS-1:0];
		end
		if (wr_prob) begin
			prob_mem[PIX_AW'(q_head.index)] <= q_head.value;
		end
		if (wr_img) begin
			img_mem[img_wr_addr] <= q_head.value[15:0];
		end
		row_rd_q  <= row_mem[ROW_AW'(mid)];
		col_rd_q  <= col_mem[col_addr];
		prob_rd_q <= prob_mem[pix_q];
		img_rd_q  <= img_mem[img_rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ru_q  <= q_head.row_u;
				cu_q  <= q_head.col_u;
				rj_q  <= q_head.row_jit;
				cj_q  <= q_head.col_jit;
				rej_q <= q_head.kind == CMD_REJECT;
				lo_q  <= '0;
				hi_q  <= IDX_BITS'(height - H_BITS'(1));
				ch_q  <= '0;
				x_q   <= COORD_NEG_ONE;
				y_q   <= COORD_NEG_ONE;
			end
			ST_ROW_CMP: begin
				if (ru_q < row_rd_q) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + IDX_BITS'(1);
				end
			end
			ST_BASE: begin
				row_q  <= lo_q;
				base_q <= PIX_AW'(lo_q * width);
				lo_q   <= '0;
				hi_q   <= IDX_BITS'(width - W_BITS'(1));
			end
			ST_COL_CMP: begin
				if (cu_q < col_rd_q) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + IDX_BITS'(1);
				end
			end
			ST_PIX: begin
				col_q <= lo_q;
				pix_q <= base_q + PIX_AW'(lo_q);
				wh_q  <= WH_BITS'(width * height);
			end
			ST_PROB_RD: begin
				den_q <= D_BITS'(wh_q * st);
			end
			ST_PROB: begin
				p_q    <= prob_rd_q;
				dnum_q <= num_y;
				drem_q <= '0;
				ddiv_q <= DD_BITS'(height);
				cnt_q  <= '0;
			end
			ST_DIV_Y: begin
				if (div_last) begin
					y_q    <= y_coord_n;
					dnum_q <= num_x;
					drem_q <= '0;
					ddiv_q <= DD_BITS'(width);
					cnt_q  <= '0;
				end else begin
					dnum_q <= quot_next;
					drem_q <= drn[DD_BITS-1:0];
					cnt_q  <= cnt_q + CNT_BITS'(1);
				end
			end
			ST_DIV_X: begin
				if (div_last) begin
					x_q <= x_coord_n;
				end
				dnum_q <= quot_next;
				drem_q <= drn[DD_BITS-1:0];
				cnt_q  <= cnt_q + CNT_BITS'(1);
			end
			ST_IMG: begin
				if (rej_q) begin
					flux_q <= '0;
				end else begin
					flux_q <= (img_rd_q != '0) ? FLUX_MAX : '0;
				end
			end
			ST_FLUX: begin
				if (flux_done) begin
					flux_q <= flux_res;
				end
			end
			ST_EMIT: begin
				if (out_free && !is_last) begin
					ch_q <= ch_q + CH_BITS'(1);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (emit_load) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_ch_q   <= 2'(ch_q);
			out_flux_q <= flux_q;
			out_rej_q  <= rej_q;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	icdf_flux #(
		.D_BITS (D_BITS)
	) u_flux (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (flux_start),
		.value  (img_rd_q),
		.prob   (p_q),
		.den    (den_q),
		.done   (flux_done),
		.result (flux_res)
	);

	assign result.valid        = out_valid_q;
	assign result.x_coord      = out_x_q;
	assign result.y_coord      = out_y_q;
	assign result.flux_channel = out_ch_q;
	assign result.flux_value   = out_flux_q;
	assign result.rejected     = out_rej_q;
	assign result.last         = out_last_q;

endmodule

@@ tb/tb_inverse_cdf_2d_sampler.sv @@
// ----------------------------------------------------------------------------
// tb_inverse_cdf_2d_sampler
// Self-checking bench for the 2-d inverse cdf sampler: loads the tables,
// sends directed and random samples under several register settings with
// random idling and a long receiver hold-off, and compares every result
// against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_inverse_cdf_2d_sampler;
	import icdf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MW = 128;
	localparam int MH = 128;
	localparam int MC = 4;
	localparam int NPIX = MW * MH;

	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic [1:0]         ch;
		logic [31:0]        flux;
		logic               rej;
		logic               last;
	} flux_res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [23:0] cfg_wdata = '0;

	icdf_item_if   item ();
	icdf_result_if result ();

	inverse_cdf_2d_sampler dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item(item.sink), .result(result.source)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [16:0] row_cdf [MH];
	logic [16:0] col_cdf [NPIX];
	logic [31:0] prob [NPIX];
	logic [15:0] img [MC][NPIX];
	int unsigned cur_w = 128, cur_h = 128, cur_nc = 1, cur_st = 1;

	flux_res_t expected_q[$];
	int  errors = 0;
	bit  send_idle = 1;
	bit  recv_idle = 1;
	int  hold_cycles = 0;
	int  hold_req = 0;
	int  hold_ack = 0;

	initial begin
		item.valid = 0;
		item.operation = OP_SAMPLE;
		item.write_index = '0;
		item.write_channel = '0;
		item.write_value = '0;
		item.row_uniform = '0;
		item.col_uniform = '0;
		item.row_jitter = '0;
		item.col_jitter = '0;
		result.ready = 0;
	end

	function automatic longint unsigned find_first(bit is_row, int unsigned base,
			int unsigned n, longint u);
		int unsigned lo, hi, mid;
		longint e;
		lo = 0;
		hi = n - 1;
		while (hi > lo) begin
			mid = (lo + hi) / 2;
			e = is_row ? longint'(row_cdf[mid]) : longint'(col_cdf[base + mid]);
			if (u < e) hi = mid;
			else lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic longint pos_scale(longint idx, longint jit, longint n);
		longint q;
		q = 2 * (idx * ONE + jit - ONE / 2) + n * ONE;
		return q / n - ONE;
	endfunction

	function automatic longint clamp1(longint v);
		return v < -ONE ? -ONE : (v > ONE ? ONE : v);
	endfunction

	function automatic logic [31:0] flux_of(longint unsigned v, longint unsigned p,
			longint unsigned d);
		logic [127:0] num, q;
		if (p == 0) return v != 0 ? FLUX_MAX : 32'd0;
		num = 128'(v * 4) << (2 * FRAC_BITS);
		q = (num / p) / d;
		return q > FLUX_MAX ? FLUX_MAX : q[31:0];
	endfunction

	task automatic predict_item(logic [2:0] op, logic [13:0] idx, logic [1:0] ch,
			logic [31:0] val, logic signed [19:0] ur, logic signed [19:0] uc,
			logic [15:0] rj, logic [15:0] cj);
		longint unsigned row, col, pix, p, d;
		longint x, y;
		bit rej;
		flux_res_t r;
		row = 0; col = 0; pix = 0; p = 0; x = -ONE; y = -ONE;
		case (op)
			OP_WR_ROW: if (idx < MH) row_cdf[idx] = val[16:0];
			OP_WR_COL: col_cdf[idx] = val[16:0];
			OP_WR_PROB: prob[idx] = val;
			OP_WR_IMG: img[ch][idx] = val[15:0];
			OP_SAMPLE: begin
				rej = ur < 0 || ur > ONE || uc < 0 || uc > ONE;
				if (!rej) begin
					row = find_first(1, 0, cur_h, ur);
					col = find_first(0, row * cur_w, cur_w, uc);
					pix = row * cur_w + col;
					p = prob[pix];
					y = clamp1(pos_scale(row, rj, cur_h) - ONE);
					x = clamp1(ONE - pos_scale(col, cj, cur_w));
				end
				d = longint'(cur_w) * cur_h * cur_st;
				for (int c = 0; c < cur_nc; c++) begin
					r.x = 18'(x);
					r.y = 18'(y);
					r.ch = 2'(c);
					r.flux = rej ? 32'd0 : flux_of(img[c][pix], p, d);
					r.rej = rej;
					r.last = (c + 1 == cur_nc);
					expected_q.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(logic [2:0] op, logic [13:0] idx, logic [1:0] ch,
			logic [31:0] val, logic signed [19:0] ur, logic signed [19:0] uc,
			logic [15:0] rj, logic [15:0] cj);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			item.valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item.valid <= 1;
		item.operation <= op;
		item.write_index <= idx;
		item.write_channel <= ch;
		item.write_value <= val;
		item.row_uniform <= ur;
		item.col_uniform <= uc;
		item.row_jitter <= rj;
		item.col_jitter <= cj;
		do @(posedge clk); while (!item.ready);
		predict_item(op, idx, ch, val, ur, uc, rj, cj);
	endtask

	task automatic write_table(logic [2:0] op, int idx, int ch, logic [31:0] val);
		send_item(op, 14'(idx), 2'(ch), val, '0, '0, '0, '0);
	endtask

	task automatic sample(logic signed [19:0] ur, logic signed [19:0] uc,
			logic [15:0] rj, logic [15:0] cj);
		send_item(OP_SAMPLE, 14'($urandom), 2'($urandom), $urandom, ur, uc, rj, cj);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		item.valid <= 0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [23:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		case (idx)
			REG_WIDTH: cur_w = v[7:0] < 1 ? 1 : (v[7:0] > MW ? MW : v[7:0]);
			REG_HEIGHT: cur_h = v[7:0] < 1 ? 1 : (v[7:0] > MH ? MH : v[7:0]);
			REG_CHANNELS: cur_nc = v[2:0] < 1 ? 1 : (v[2:0] > MC ? MC : v[2:0]);
			default: cur_st = v == 0 ? 1 : v;
		endcase
	endtask

	// fill every table over a w x h distribution with a random monotone-ish cdf
	task automatic load_dist(int w, int h);
		logic [16:0] acc;
		acc = 0;
		for (int r = 0; r < h; r++) begin
			acc = (r == h - 1) ? 17'(ONE) : 17'(acc + $urandom_range(0, ONE / h * 2));
			write_table(OP_WR_ROW, r, 0, {15'($urandom), acc});
		end
		for (int r = 0; r < h; r++) begin
			acc = 0;
			for (int c = 0; c < w; c++) begin
				acc = 17'(acc + $urandom_range(0, ONE / w * 2));
				write_table(OP_WR_COL, r * w + c, 0, {15'($urandom), acc});
				write_table(OP_WR_PROB, r * w + c, 0,
					$urandom_range(0, 7) == 0 ? 32'd0 : $urandom);
				for (int k = 0; k < MC; k++)
					write_table(OP_WR_IMG, r * w + c, k, $urandom);
			end
		end
	endtask

	function automatic logic signed [19:0] rand_uniform();
		case ($urandom_range(0, 9))
			0: return 20'($urandom);
			1: return 20'(ONE + $urandom_range(1, 3));
			2: return -20'($urandom_range(1, 5));
			3: return 20'(ONE);
			4: return 20'd0;
			default: return 20'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic test_directed();
		set_reg(REG_WIDTH, 24'd3);
		set_reg(REG_HEIGHT, 24'd2);
		set_reg(REG_CHANNELS, 24'd4);
		set_reg(REG_SAMPLES, 24'd1);
		load_dist(3, 2);
		write_table(OP_WR_PROB, 0, 0, 0);
		write_table(OP_WR_IMG, 0, 0, 0);
		write_table(OP_WR_ROW, 14'h3FFF, 0, 32'hFFFF_FFFF);
		write_table(OP_WR_COL, NPIX - 1, 0, 32'h1_0000);
		send_item(3'd5, 14'h3FFF, 2'd3, 32'hFFFF_FFFF, -20'sd1, -20'sd1, 16'hFFFF, 16'hFFFF);
		send_item(3'd7, '0, '0, '0, '0, '0, '0, '0);
		sample('0, '0, '0, '0);
		sample(20'(ONE), 20'(ONE), 16'hFFFF, 16'hFFFF);
		sample('0, '0, 16'hFFFF, '0);
		sample(20'(ONE / 2), 20'(ONE / 3), 16'h8000, 16'h8000);
		sample(-20'sd1, '0, '0, '0);
		sample('0, 20'(ONE + 1), '0, '0);
		sample(20'sh7FFFF, 20'sh80000, 16'hAAAA, 16'h5555);
		sample(20'sh80000, 20'sh7FFFF, 16'h5555, 16'hAAAA);
	endtask

	task automatic test_extremes();
		set_reg(REG_WIDTH, 24'd0);
		set_reg(REG_HEIGHT, 24'd0);
		set_reg(REG_CHANNELS, 24'd0);
		set_reg(REG_SAMPLES, 24'd0);
		load_dist(1, 1);
		for (int i = 0; i < 6; i++)
			sample(rand_uniform(), rand_uniform(), 16'($urandom), 16'($urandom));
		set_reg(REG_WIDTH, 24'd255);
		set_reg(REG_HEIGHT, 24'd200);
		set_reg(REG_CHANNELS, 24'd7);
		set_reg(REG_SAMPLES, 24'hFFFFFF);
		// row 0 holds 0 and the rest 1.0, so a row uniform below one picks row 1;
		// only the entries on the search paths to column 0 and column 127 are loaded
		for (int k = 0; k < 7; k++) begin
			write_table(OP_WR_ROW, (1 << k) - 1, 0, k == 0 ? 32'd0 : 32'(ONE));
			write_table(OP_WR_COL, MW + (1 << k) - 1, 0, 32'(ONE));
			write_table(OP_WR_COL, MW + MW - 1 - (1 << k), 0, 32'(ONE));
		end
		for (int c = 0; c < MW; c += MW - 1) begin
			write_table(OP_WR_PROB, MW + c, 0, $urandom);
			for (int k = 0; k < MC; k++) write_table(OP_WR_IMG, MW + c, k, $urandom);
		end
		for (int i = 0; i < 6; i++)
			sample(20'($urandom_range(0, ONE - 1)),
				$urandom_range(0, 1) == 0 ? 20'(ONE) : 20'($urandom_range(0, ONE - 1)),
				16'($urandom), 16'($urandom));
		set_reg(REG_SAMPLES, 24'd1);
		set_reg(REG_WIDTH, 24'd2);
		set_reg(REG_HEIGHT, 24'd2);
		set_reg(REG_CHANNELS, 24'd1);
		load_dist(2, 2);
		for (int i = 0; i < 6; i++)
			sample(rand_uniform(), rand_uniform(), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_random(int n);
		int w, h;
		for (int ph = 0; ph < 4; ph++) begin
			w = $urandom_range(1, 3);
			h = $urandom_range(1, 3);
			set_reg(REG_WIDTH, 24'(w));
			set_reg(REG_HEIGHT, 24'(h));
			set_reg(REG_CHANNELS, 24'($urandom_range(1, 4)));
			set_reg(REG_SAMPLES,
				$urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 9)));
			load_dist(w, h);
			if (ph == 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					write_table(OP_WR_IMG, $urandom_range(0, w * h - 1), $urandom_range(0, 3),
						$urandom);
				else if ($urandom_range(0, 19) == 0)
					send_item(3'($urandom_range(5, 7)), 14'($urandom), 2'($urandom),
						$urandom, 20'($urandom), 20'($urandom), 16'($urandom),
						16'($urandom));
				else
					sample(rand_uniform(), rand_uniform(), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 12; i++)
			sample(rand_uniform(), rand_uniform(), 16'($urandom), 16'($urandom));
	endtask

	// result side ready and checking
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_cycles <= 600;
			result.ready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result.ready <= 0;
		end else if (recv_idle && $urandom_range(0, 15) == 0) begin
			result.ready <= 0;
			hold_cycles <= $urandom_range(1, 11);
		end else begin
			result.ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		flux_res_t got, exp;
		if (arst_n && result.valid && result.ready) begin
			got = {result.x_coord, result.y_coord, result.flux_channel, result.flux_value,
				result.rejected, result.last};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				exp = expected_q.pop_front();
				if (got !== exp) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_backpressure();
		test_random(20);
		recv_idle = 0;
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("FAILURE");
		$finish;
	end

endmodule
